// ===== sv/hmpf_pkg.sv =====
package hmpf_pkg;

  localparam int DefMaxBins      = 1024;
  localparam int DefMaxHarmonics = 4;
  localparam int NoteLimit       = 8;
  localparam int GuardBins       = 6;
  localparam int ProdFactors     = 4;

  localparam int MagW  = 16;
  localparam int FundW = 10;
  localparam int HarmW = 3;
  localparam int NoteW = 4;
  localparam int ProdW = 64;
  localparam int CfgW  = 4;

  localparam logic [HarmW-1:0] HarmReset  = 3'd3;
  localparam logic [NoteW-1:0] NotesReset = 4'd4;

  typedef enum logic {
    CfgHarmonicCount = 1'b0,
    CfgMaxNotes      = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StLoad,
    StScInit,
    StScChk,
    StScRd,
    StScWait,
    StMul0,
    StMul1,
    StCmp,
    StPeak,
    StDecide,
    StSupInit,
    StSupSet,
    StSupWr,
    StFin
  } state_e;

  typedef struct packed {
    logic [MagW-1:0] magnitude;
    logic            last_bin;
  } in_t;

  typedef struct packed {
    logic [FundW-1:0] fundamental_bin;
    logic [MagW-1:0]  peak_power;
    logic             last_note;
  } out_t;

endpackage

// ===== sv/hmpf_prod.sv =====
module hmpf_prod (
  input  logic                                                 clk_i,
  input  logic [hmpf_pkg::ProdFactors-1:0][hmpf_pkg::MagW-1:0] fac_i,
  output logic [hmpf_pkg::ProdW-1:0]                           prod_o
);

  logic [2*hmpf_pkg::MagW-1:0] ab_q;
  logic [2*hmpf_pkg::MagW-1:0] cd_q;
  logic [hmpf_pkg::ProdW-1:0]  prod_q;

  always_ff @(posedge clk_i) begin
    ab_q   <= (2*hmpf_pkg::MagW)'(fac_i[0]) * (2*hmpf_pkg::MagW)'(fac_i[1]);
    cd_q   <= (2*hmpf_pkg::MagW)'(fac_i[2]) * (2*hmpf_pkg::MagW)'(fac_i[3]);
    prod_q <= hmpf_pkg::ProdW'(ab_q) * hmpf_pkg::ProdW'(cd_q);
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/hps_multi_pitch_finder_unit.sv =====
// Harmonic product spectrum pitch finder. Bins are taken one per request at one per cycle
// into a spectrum memory with a separate read and write port; the request flagged as the last
// bin starts the search, and no bin is taken until the final note of that spectrum has been
// handed to the output register. Each pass scores every candidate bin k with H memory reads
// followed by the two-stage product and a compare; the note is then checked and its harmonics
// cleared at one memory write per cycle, up to 13*H writes. Up to max_notes passes (one when
// it is zero, at most eight) run per spectrum.
module hps_multi_pitch_finder_unit #(
  parameter int MAX_BINS      = hmpf_pkg::DefMaxBins,
  parameter int MAX_HARMONICS = hmpf_pkg::DefMaxHarmonics
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [hmpf_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  hmpf_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output hmpf_pkg::out_t            out_data_o
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int LW = $clog2(MAX_BINS + hmpf_pkg::GuardBins + 2);
  localparam int XW = LW + hmpf_pkg::HarmW;
  localparam int MW = hmpf_pkg::MagW;

  hmpf_pkg::state_e state_q, state_d;

  logic [hmpf_pkg::HarmW-1:0] harm_q;
  logic [hmpf_pkg::NoteW-1:0] notes_q;
  logic [hmpf_pkg::HarmW-1:0] eff_h;
  logic [hmpf_pkg::NoteW-1:0] eff_n;

  logic [MW-1:0] mem [MAX_BINS];
  logic [MW-1:0] rdata_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [MW-1:0] wdata;
  logic [AW-1:0] raddr;

  logic [LW-1:0] cnt_q;
  logic [LW-1:0] len_q;
  logic [LW-1:0] k_q;
  logic [LW-1:0] addr_q;
  logic [1:0]    slot_q;
  logic          cap_v_q;
  logic [1:0]    cap_slot_q;
  logic [hmpf_pkg::ProdFactors-1:0][MW-1:0] fac_q;
  logic [hmpf_pkg::ProdW-1:0] prod;
  logic [hmpf_pkg::ProdW-1:0] best_prod_q;
  logic [LW-1:0] best_q;
  logic [MW-1:0] ref_q;
  logic [hmpf_pkg::NoteW-1:0] pass_q;
  logic          pend_v_q;
  logic [LW-1:0] pend_bin_q;
  logic [MW-1:0] pend_pow_q;
  logic [hmpf_pkg::HarmW-1:0] mh_q;
  logic [LW-1:0] c_q;
  logic [LW-1:0] i_q;
  logic [LW-1:0] hi_q;
  logic          out_valid_q;
  hmpf_pkg::out_t out_q;

  logic          in_acc;
  logic          out_free;
  logic          kchk_ok;
  logic          rd_last;
  logic          stop;
  logic          emit_ok;
  logic [MW+3:0] peak10;
  logic [LW-1:0] load_len;
  logic          out_load;
  logic          out_last;

  always_comb begin
    if (harm_q == '0) begin
      eff_h = hmpf_pkg::HarmW'(1);
    end else if (harm_q > hmpf_pkg::HarmW'(MAX_HARMONICS)) begin
      eff_h = hmpf_pkg::HarmW'(MAX_HARMONICS);
    end else begin
      eff_h = harm_q;
    end
    if (notes_q == '0) begin
      eff_n = hmpf_pkg::NoteW'(1);
    end else if (notes_q > hmpf_pkg::NoteW'(hmpf_pkg::NoteLimit)) begin
      eff_n = hmpf_pkg::NoteW'(hmpf_pkg::NoteLimit);
    end else begin
      eff_n = notes_q;
    end
  end

  assign in_acc   = in_valid_i && (state_q == hmpf_pkg::StLoad);
  assign out_free = !out_valid_q || !out_stall_i;
  assign kchk_ok  = (XW'(k_q + LW'(1)) * XW'(eff_h)) <= XW'(len_q);
  assign rd_last  = ({1'b0, slot_q} == (eff_h - hmpf_pkg::HarmW'(1)));
  assign peak10   = {1'b0, rdata_q, 3'b000} + {3'b000, rdata_q, 1'b0};
  assign stop     = (pass_q != '0) && (peak10 < {4'b0000, ref_q});
  assign emit_ok  = !pend_v_q || out_free;
  assign load_len = (cnt_q < LW'(MAX_BINS)) ? cnt_q + LW'(1) : cnt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hmpf_pkg::StLoad: begin
        if (in_acc && in_data_i.last_bin) begin
          state_d = hmpf_pkg::StScInit;
        end
      end
      hmpf_pkg::StScInit: state_d = hmpf_pkg::StScChk;
      hmpf_pkg::StScChk:  state_d = kchk_ok ? hmpf_pkg::StScRd : hmpf_pkg::StPeak;
      hmpf_pkg::StScRd: begin
        if (rd_last) begin
          state_d = hmpf_pkg::StScWait;
        end
      end
      hmpf_pkg::StScWait: state_d = hmpf_pkg::StMul0;
      hmpf_pkg::StMul0:   state_d = hmpf_pkg::StMul1;
      hmpf_pkg::StMul1:   state_d = hmpf_pkg::StCmp;
      hmpf_pkg::StCmp:    state_d = hmpf_pkg::StScChk;
      hmpf_pkg::StPeak:   state_d = hmpf_pkg::StDecide;
      hmpf_pkg::StDecide: begin
        if (stop) begin
          state_d = hmpf_pkg::StFin;
        end else if (emit_ok) begin
          state_d = hmpf_pkg::StSupInit;
        end
      end
      hmpf_pkg::StSupInit: state_d = hmpf_pkg::StSupSet;
      hmpf_pkg::StSupSet:  state_d = hmpf_pkg::StSupWr;
      hmpf_pkg::StSupWr: begin
        if (i_q >= hi_q) begin
          if (mh_q == eff_h) begin
            state_d = (pass_q == eff_n) ? hmpf_pkg::StFin : hmpf_pkg::StScInit;
          end else begin
            state_d = hmpf_pkg::StSupSet;
          end
        end
      end
      hmpf_pkg::StFin: begin
        if (out_free) begin
          state_d = hmpf_pkg::StLoad;
        end
      end
      default: state_d = hmpf_pkg::StLoad;
    endcase
  end

  always_comb begin
    we       = 1'b0;
    waddr    = cnt_q[AW-1:0];
    wdata    = in_data_i.magnitude;
    raddr    = best_q[AW-1:0];
    out_load = 1'b0;
    out_last = 1'b0;
    case (state_q)
      hmpf_pkg::StLoad: begin
        we = in_acc && (cnt_q < LW'(MAX_BINS));
      end
      hmpf_pkg::StScRd: begin
        raddr = addr_q[AW-1:0];
      end
      hmpf_pkg::StDecide: begin
        out_load = !stop && pend_v_q && out_free;
      end
      hmpf_pkg::StSupWr: begin
        we    = i_q < hi_q;
        waddr = i_q[AW-1:0];
        wdata = '0;
      end
      hmpf_pkg::StFin: begin
        out_load = out_free;
        out_last = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  hmpf_prod u_prod (
    .clk_i  (clk_i),
    .fac_i  (fac_q),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hmpf_pkg::StLoad;
      harm_q      <= hmpf_pkg::HarmReset;
      notes_q     <= hmpf_pkg::NotesReset;
      cnt_q       <= '0;
      len_q       <= '0;
      k_q         <= '0;
      addr_q      <= '0;
      slot_q      <= '0;
      cap_v_q     <= 1'b0;
      cap_slot_q  <= '0;
      fac_q       <= '0;
      best_prod_q <= '0;
      best_q      <= '0;
      ref_q       <= '0;
      pass_q      <= '0;
      pend_v_q    <= 1'b0;
      pend_bin_q  <= '0;
      pend_pow_q  <= '0;
      mh_q        <= '0;
      c_q         <= '0;
      i_q         <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hmpf_pkg::CfgHarmonicCount: harm_q  <= cfg_data_i[hmpf_pkg::HarmW-1:0];
          hmpf_pkg::CfgMaxNotes:      notes_q <= cfg_data_i;
          default:                    harm_q  <= harm_q;
        endcase
      end
      cap_v_q    <= (state_q == hmpf_pkg::StScRd);
      cap_slot_q <= slot_q;
      if (cap_v_q) begin
        fac_q[cap_slot_q] <= rdata_q;
      end
      if (out_load) begin
        out_valid_q           <= 1'b1;
        out_q.fundamental_bin <= hmpf_pkg::FundW'(pend_bin_q);
        out_q.peak_power      <= pend_pow_q;
        out_q.last_note       <= out_last;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        hmpf_pkg::StLoad: begin
          if (in_acc) begin
            if (in_data_i.last_bin) begin
              len_q <= load_len;
              cnt_q <= '0;
            end else begin
              cnt_q <= load_len;
            end
          end
        end
        hmpf_pkg::StScInit: begin
          k_q         <= LW'(1);
          best_prod_q <= '0;
          best_q      <= '0;
        end
        hmpf_pkg::StScChk: begin
          addr_q <= k_q;
          slot_q <= '0;
          for (int f = 0; f < hmpf_pkg::ProdFactors; f++) begin
            fac_q[f] <= MW'(1);
          end
        end
        hmpf_pkg::StScRd: begin
          addr_q <= addr_q + k_q;
          slot_q <= slot_q + 2'd1;
        end
        hmpf_pkg::StCmp: begin
          if (prod > best_prod_q) begin
            best_prod_q <= prod;
            best_q      <= k_q;
          end
          k_q <= k_q + LW'(1);
        end
        hmpf_pkg::StDecide: begin
          if (stop) begin
            pass_q <= pass_q;
          end else if (emit_ok) begin
            if (pass_q == '0) begin
              ref_q <= rdata_q;
            end
            pend_v_q   <= 1'b1;
            pend_bin_q <= best_q;
            pend_pow_q <= rdata_q;
            pass_q     <= pass_q + hmpf_pkg::NoteW'(1);
          end
        end
        hmpf_pkg::StSupInit: begin
          mh_q <= hmpf_pkg::HarmW'(1);
          c_q  <= best_q;
        end
        hmpf_pkg::StSupSet: begin
          i_q  <= (c_q > LW'(hmpf_pkg::GuardBins)) ? c_q - LW'(hmpf_pkg::GuardBins) : '0;
          hi_q <= ((c_q + LW'(hmpf_pkg::GuardBins + 1)) > len_q) ?
                  len_q : c_q + LW'(hmpf_pkg::GuardBins + 1);
        end
        hmpf_pkg::StSupWr: begin
          if (i_q < hi_q) begin
            i_q <= i_q + LW'(1);
          end else begin
            mh_q <= mh_q + hmpf_pkg::HarmW'(1);
            c_q  <= c_q + best_q;
          end
        end
        hmpf_pkg::StFin: begin
          if (out_free) begin
            pend_v_q <= 1'b0;
            pass_q   <= '0;
          end
        end
        default: begin
          pass_q <= pass_q;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != hmpf_pkg::StLoad);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/tb_hps_multi_pitch_finder_unit.sv =====
`timescale 1ns / 100ps

module tb_hps_multi_pitch_finder_unit;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic [hmpf_pkg::CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  hmpf_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hmpf_pkg::out_t out_data;

  hps_multi_pitch_finder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #10 clk_i = ~clk_i;

  logic [hmpf_pkg::MagW-1:0] spec_shadow [hmpf_pkg::DefMaxBins];
  int unsigned bins_held = 0;
  logic [hmpf_pkg::HarmW-1:0] harm_reg = hmpf_pkg::HarmReset;
  logic [hmpf_pkg::NoteW-1:0] notes_reg = hmpf_pkg::NotesReset;
  hmpf_pkg::out_t expected_notes [$];
  int errors = 0;
  bit quiet_mode = 1'b0;
  bit long_hold = 1'b0;

  function automatic void predict_bin(logic [hmpf_pkg::MagW-1:0] mag, bit last);
    int unsigned len, h, lim, n, k, j, m, i, lo, hi, bidx, pass;
    longint unsigned p, bp;
    logic [hmpf_pkg::MagW-1:0] peak, ref_pwr;
    hmpf_pkg::out_t r;
    hmpf_pkg::out_t batch [$];
    if (bins_held < hmpf_pkg::DefMaxBins) begin
      spec_shadow[bins_held] = mag;
      bins_held++;
    end
    if (!last) return;
    len = bins_held;
    h = (harm_reg == 0) ? 1 : (harm_reg > hmpf_pkg::DefMaxHarmonics) ?
        hmpf_pkg::DefMaxHarmonics : harm_reg;
    lim = (notes_reg == 0) ? 1 : (notes_reg > hmpf_pkg::NoteLimit) ?
          hmpf_pkg::NoteLimit : notes_reg;
    n = 0;
    ref_pwr = '0;
    for (pass = 0; pass < lim; pass++) begin
      bp = 0;
      bidx = 0;
      for (k = 1; k < len / h; k++) begin
        p = 1;
        for (j = 1; j <= h; j++) p = p * spec_shadow[k * j];
        if (p > bp) begin
          bp = p;
          bidx = k;
        end
      end
      peak = (bidx < len) ? spec_shadow[bidx] : '0;
      if (n == 0) ref_pwr = peak;
      else if ((32'(peak) * 10) < 32'(ref_pwr)) break;
      r.fundamental_bin = bidx[hmpf_pkg::FundW-1:0];
      r.peak_power = peak;
      r.last_note = 1'b0;
      batch.push_back(r);
      n++;
      for (m = 1; m <= h; m++) begin
        lo = (m * bidx > hmpf_pkg::GuardBins) ? m * bidx - hmpf_pkg::GuardBins : 0;
        hi = m * bidx + hmpf_pkg::GuardBins + 1;
        if (hi > len) hi = len;
        for (i = lo; i < hi; i++) spec_shadow[i] = '0;
      end
    end
    if (n > 0) batch[n - 1].last_note = 1'b1;
    foreach (batch[b]) expected_notes.push_back(batch[b]);
    bins_held = 0;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (quiet_mode || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_bin(logic [hmpf_pkg::MagW-1:0] mag, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data.magnitude <= mag;
    in_data.last_bin <= last;
    do @(posedge clk_i); while (in_stall);
    predict_bin(mag, last);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_notes.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(hmpf_pkg::cfg_idx_e idx, logic [hmpf_pkg::CfgW-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == hmpf_pkg::CfgHarmonicCount) harm_reg = val[hmpf_pkg::HarmW-1:0];
    else notes_reg = val;
  endtask

  task automatic send_spectrum(int len, bit rich);
    logic [hmpf_pkg::MagW-1:0] s [];
    int f, c, t;
    s = new[len];
    foreach (s[i]) s[i] = rich ? hmpf_pkg::MagW'($urandom_range(0, 200)) :
                                 hmpf_pkg::MagW'($urandom());
    if (rich) begin
      c = $urandom_range(1, 3);
      repeat (c) begin
        f = $urandom_range(2, (len / 4 > 2) ? len / 4 : 2);
        for (t = 1; t <= 4; t++)
          if (f * t < len) s[f * t] = hmpf_pkg::MagW'($urandom_range(1000, 65535));
      end
    end
    foreach (s[i]) send_bin(s[i], i == len - 1);
  endtask

  task automatic test_directed();
    send_bin(16'hFFFF, 1'b1);
    send_bin(16'h0000, 1'b1);
    send_bin(16'h0000, 1'b0);
    send_bin(16'h0000, 1'b1);
    send_bin(16'h0000, 1'b0);
    send_bin(16'hAAAA, 1'b0);
    send_bin(16'h5555, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h0001, 1'b0);
    send_bin(16'h8000, 1'b0);
    send_bin(16'hFFFF, 1'b1);
    for (int i = 0; i < 12; i++) send_bin((i % 3 == 0) ? 16'hFFFF : 16'h0001, i == 11);
  endtask

  task automatic test_config_sweep();
    logic [hmpf_pkg::CfgW-1:0] harm_vals [5] = '{4'd0, 4'd1, 4'd4, 4'd7, 4'd10};
    logic [hmpf_pkg::CfgW-1:0] note_vals [5] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd5};
    for (int i = 0; i < 5; i++) begin
      write_reg(hmpf_pkg::CfgHarmonicCount, harm_vals[i]);
      write_reg(hmpf_pkg::CfgMaxNotes, note_vals[i]);
      send_spectrum($urandom_range(16, 30), 1'b1);
      send_spectrum($urandom_range(2, 8), 1'b0);
    end
    write_reg(hmpf_pkg::CfgHarmonicCount, 4'd2);
    write_reg(hmpf_pkg::CfgMaxNotes, 4'd8);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 115) begin
      if ($urandom_range(0, 7) == 0) begin
        write_reg(hmpf_pkg::CfgHarmonicCount, hmpf_pkg::CfgW'($urandom_range(1, 4)));
        write_reg(hmpf_pkg::CfgMaxNotes, hmpf_pkg::CfgW'($urandom_range(1, 8)));
      end
      quiet_mode = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) begin
        send_spectrum($urandom_range(1, 6), 1'b0);
        sent += 3;
      end else begin
        send_spectrum($urandom_range(12, 40), 1'b1);
        sent += 26;
      end
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 4; i++) send_spectrum($urandom_range(6, 10), 1'b1);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (quiet_mode) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 40) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        out_stall <= ($urandom_range(0, 9) < 3);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_notes.size() == 0) begin
        $error("unexpected note: bin %0d power %0d", out_data.fundamental_bin,
               out_data.peak_power);
        errors++;
      end else begin
        if (out_data.fundamental_bin !== expected_notes[0].fundamental_bin) begin
          $error("fundamental_bin: expected %0d, got %0d",
                 expected_notes[0].fundamental_bin, out_data.fundamental_bin);
          errors++;
        end
        if (out_data.peak_power !== expected_notes[0].peak_power) begin
          $error("peak_power: expected %0d, got %0d",
                 expected_notes[0].peak_power, out_data.peak_power);
          errors++;
        end
        if (out_data.last_note !== expected_notes[0].last_note) begin
          $error("last_note: expected %0d, got %0d",
                 expected_notes[0].last_note, out_data.last_note);
          errors++;
        end
        void'(expected_notes.pop_front());
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    settle();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #30ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
